FILE: sv/fsc_pkg.sv
// fsc_pkg: shared types and constants for the frame sum checker.
// No dependencies; imported by every fsc_* module and the top level.

package fsc_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hEF;
    localparam logic [7:0] HDR_SECOND = 8'h01;
    localparam logic [7:0] MIN_LEN    = 8'd2;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_TYPE    = 3'd2,
        PH_SKIP    = 3'd3,
        PH_LEN     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CSUM_HI = 3'd6,
        PH_CSUM_LO = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_BAD_LENGTH = 2'd2,
        ST_BAD_SUM    = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
    } in_item_t;

    typedef struct packed {
        logic       frame_ok;
        status_t    status;
        logic [7:0] packet_type;
    } result_t;

endpackage

FILE: sv/fsc_in_reg.sv
// fsc_in_reg: input register stage for the frame sum checker.
// Depends on fsc_pkg (in_item_t).

module fsc_in_reg
    import fsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    in_item_t item_reg;

    // Register empties as the parse stage takes its item.
    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: sv/fsc_parse.sv
// fsc_parse: frame parser state and one-byte step logic.
// Depends on fsc_pkg (phase_t, status_t, in_item_t, result_t).

module fsc_parse
    import fsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  in_item_t item,
    output logic     res_valid,
    output result_t  res
);

    phase_t      phase_reg,   phase_next;
    logic [15:0] sum_reg,     sum_next;
    logic [7:0]  left_reg,    left_next;
    logic [7:0]  csum_hi_reg, csum_hi_next;
    logic [7:0]  type_reg,    type_next;

    logic [7:0]  b;
    logic [7:0]  left_dec;

    assign b        = item.data_byte;
    assign left_dec = left_reg - 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        sum_next     = sum_reg;
        left_next    = left_reg;
        csum_hi_next = csum_hi_reg;
        type_next    = type_reg;
        res_valid    = 1'b0;
        res.status   = ST_OK;
        res.packet_type = type_reg;
        if (item.first)
        begin
            // restart: any frame in progress is dropped
            sum_next     = '0;
            left_next    = '0;
            csum_hi_next = '0;
            type_next    = '0;
            if (b != HDR_FIRST)
            begin
                res_valid       = 1'b1;
                res.status      = ST_BAD_HEADER;
                res.packet_type = '0;
                phase_next      = PH_IDLE;
            end
            else
            begin
                phase_next = PH_HDR2;
            end
        end
        else
        begin
            case (phase_reg)
                PH_HDR2:
                begin
                    if (b != HDR_SECOND)
                    begin
                        res_valid       = 1'b1;
                        res.status      = ST_BAD_HEADER;
                        res.packet_type = '0;
                        phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_next  = b;
                    sum_next   = {8'd0, b};
                    phase_next = PH_SKIP;
                end
                PH_SKIP:
                begin
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (b < MIN_LEN)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_BAD_LENGTH;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        sum_next   = sum_reg + {8'd0, b};
                        left_next  = b - MIN_LEN;
                        phase_next = (b == MIN_LEN) ? PH_CSUM_HI : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    sum_next  = sum_reg + {8'd0, b};
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next = PH_CSUM_HI;
                    end
                end
                PH_CSUM_HI:
                begin
                    csum_hi_next = b;
                    phase_next   = PH_CSUM_LO;
                end
                PH_CSUM_LO:
                begin
                    res_valid  = 1'b1;
                    res.status = ({csum_hi_reg, b} == sum_reg) ? ST_OK : ST_BAD_SUM;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    // idle: unmarked bytes are dropped
                end
            endcase
        end
        res.frame_ok = (res.status == ST_OK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            sum_reg     <= '0;
            left_reg    <= '0;
            csum_hi_reg <= '0;
            type_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            sum_reg     <= sum_next;
            left_reg    <= left_next;
            csum_hi_reg <= csum_hi_next;
            type_reg    <= type_next;
        end
    end

endmodule

FILE: sv/fsc_out_reg.sv
// fsc_out_reg: result register holding one verdict until transferred.
// Depends on fsc_pkg (result_t).

module fsc_out_reg
    import fsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

FILE: sv/frame_sum_checker.sv
// frame_sum_checker: top level of the additive checksum frame checker.
// Depends on fsc_pkg, fsc_in_reg, fsc_parse and fsc_out_reg.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | in_valid, in_ready, data_byte, first  | in
//  result  | out_valid, out_ready, frame_ok,       | out
//          | status, packet_type                  |
//
// One byte is taken per cycle while the result side is not stalled; the byte
// sits in the input register and its verdict, if any, is loaded into the
// result register when the parse stage steps. The parse step is combinational:
// a small 16-bit adder, a byte compare and the phase register.
// Reset (rst_n low, asynchronous) empties both registers and puts the parser idle.
// A stall on the result side holds the verdict and freezes the parse stage;
// one more byte can land in the input register, then in_ready drops.

module frame_sum_checker
    import fsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       first,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       frame_ok,
    output logic [1:0] status,
    output logic [7:0] packet_type
);

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    logic     res_valid;
    result_t  res;
    result_t  out_res;

    assign in_item.data_byte = data_byte;
    assign in_item.first     = first;

    // Parse stage moves whenever the result register is free or being emptied;
    // conservative for bytes that give no verdict, but cheap and still full rate.
    assign advance = !out_valid || out_ready;

    fsc_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    fsc_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (item_valid && advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    fsc_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (item_valid && advance && res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign frame_ok    = out_res.frame_ok;
    assign status      = out_res.status;
    assign packet_type = out_res.packet_type;

endmodule

FILE: sv/fsc_checker.sv
// fsc_checker: port-level assertions for frame_sum_checker, bound to the top.
// Depends on fsc_pkg (status_t) and frame_sum_checker.

module fsc_checker
    import fsc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       frame_ok,
    input logic [1:0] status,
    input logic [7:0] packet_type
);

    // a stalled verdict holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(packet_type) && $stable(frame_ok))
        else $error("verdict changed while stalled");

    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_ok == (status == ST_OK)))
        else $error("frame_ok disagrees with status");

    a_hdr_type: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_BAD_HEADER |-> packet_type == 8'd0)
        else $error("bad header verdict carries a type byte");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with result register empty");

endmodule

bind frame_sum_checker fsc_checker u_fsc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_ok    (frame_ok),
    .status      (status),
    .packet_type (packet_type)
);

FILE: bench/frame_sum_checker_tb.sv
// frame_sum_checker_tb: self-checking bench for the additive checksum frame checker.
// Depends on fsc_pkg and the frame_sum_checker RTL; drives random frames through
// both valid/ready channels and checks every verdict against a built-in predictor.

module frame_sum_checker_tb
    import fsc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Keeps its own copy of the parser state and queues the verdict that each
    // accepted byte settles; verdicts leaving the block are matched in order.
    class frame_scoreboard;
        phase_t      phase;
        logic [15:0] running_sum;
        logic [7:0]  bytes_left;
        logic [7:0]  checksum_high;
        logic [7:0]  type_seen;
        result_t     verdicts_due[$];
        int          errors;

        function new();
            phase         = PH_IDLE;
            running_sum   = '0;
            bytes_left    = '0;
            checksum_high = '0;
            type_seen     = '0;
            errors        = 0;
        endfunction

        function void post_verdict(status_t st, logic [7:0] ty);
            result_t r;
            r.frame_ok    = (st == ST_OK);
            r.status      = st;
            r.packet_type = ty;
            verdicts_due.push_back(r);
            phase = PH_IDLE;
        endfunction

        // Called once per accepted input transfer.
        function void note_byte(logic [7:0] b, logic f);
            logic [15:0] rx_sum;
            if (f)
            begin
                // first-marked byte: drop anything in progress and restart
                running_sum   = '0;
                bytes_left    = '0;
                checksum_high = '0;
                type_seen     = '0;
                if (b != HDR_FIRST)
                    post_verdict(ST_BAD_HEADER, 8'h00);
                else
                    phase = PH_HDR2;
                return;
            end
            case (phase)
                PH_HDR2:
                begin
                    if (b != HDR_SECOND)
                        post_verdict(ST_BAD_HEADER, 8'h00);
                    else
                        phase = PH_TYPE;
                end
                PH_TYPE:
                begin
                    type_seen   = b;
                    running_sum = {8'h00, b};
                    phase       = PH_SKIP;
                end
                PH_SKIP:
                    phase = PH_LEN;
                PH_LEN:
                begin
                    if (b < MIN_LEN)
                        post_verdict(ST_BAD_LENGTH, type_seen);
                    else
                    begin
                        running_sum = running_sum + {8'h00, b};
                        bytes_left  = b - MIN_LEN;
                        if (bytes_left == 8'd0)
                            phase = PH_CSUM_HI;
                        else
                            phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    running_sum = running_sum + {8'h00, b};
                    bytes_left  = bytes_left - 8'd1;
                    if (bytes_left == 8'd0)
                        phase = PH_CSUM_HI;
                end
                PH_CSUM_HI:
                begin
                    checksum_high = b;
                    phase         = PH_CSUM_LO;
                end
                PH_CSUM_LO:
                begin
                    rx_sum = {checksum_high, b};
                    if (rx_sum == running_sum)
                        post_verdict(ST_OK, type_seen);
                    else
                        post_verdict(ST_BAD_SUM, type_seen);
                end
                default: ;
            endcase
        endfunction

        // Called once per accepted result transfer.
        function void check_verdict(logic ok, logic [1:0] st, logic [7:0] ty);
            result_t want;
            if (verdicts_due.size() == 0)
            begin
                $error("unexpected verdict: frame_ok=%0d status=%0d packet_type=%02h",
                       ok, st, ty);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (ok !== want.frame_ok)
            begin
                $error("frame_ok: expected %0d, got %0d", want.frame_ok, ok);
                errors++;
            end
            if (st !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, st);
                errors++;
            end
            if (ty !== want.packet_type)
            begin
                $error("packet_type: expected %02h, got %02h", want.packet_type, ty);
                errors++;
            end
        endfunction
    endclass

    localparam int BYTE_TARGET   = 1950;  // frame bytes to offer before stopping
    localparam int QUIET_FROM    = 1700;  // no gaps or stalls after this many
    localparam int SQUEEZE_AT    = 600;   // when the long receiver hold-off starts
    localparam int SQUEEZE_LEN   = 300;   // cycles of that hold-off
    localparam int DRAIN_CYCLES  = 8;     // idle time after the last expected verdict

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       first;
    logic       out_valid;
    logic       out_ready;
    logic       frame_ok;
    logic [1:0] status;
    logic [7:0] packet_type;

    frame_scoreboard board = new();
    int              bytes_sent = 0;     // frame bytes accepted, noise excluded
    bit              squeeze_done = 0;

    frame_sum_checker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .first       (first),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_ok    (frame_ok),
        .status      (status),
        .packet_type (packet_type)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Gaps and stalls come in bands: every fourth band of 200 bytes runs
    // without them, and the tail of the run is gap-free too.
    function automatic bit gaps_allowed();
        return bytes_sent < QUIET_FROM && ((bytes_sent / 200) % 4) != 3;
    endfunction

    // Offers one byte, called and returning at a falling edge. Valid is only
    // dropped for a gap, never between back-to-back transfers.
    task automatic send_byte(input logic [7:0] b, input logic f, input bit counts);
        if (gaps_allowed() && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        first     <= f;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_byte(b, f);
        if (counts)
            bytes_sent++;
        @(negedge clk);
    endtask

    // Builds a frame with header, type, a spare byte, length, payload and
    // checksum. A length below two ends the frame at the length byte. With
    // chop set the frame is cut short, so the next first-marked byte restarts
    // the parser mid-frame.
    task automatic send_frame(input logic [7:0] pkt, input logic [7:0] len,
                              input bit all_ones, input bit sum_good, input bit chop);
        logic [7:0]  fb[$];
        logic [15:0] sum;
        logic [7:0]  pb;
        int          n;
        fb.push_back(HDR_FIRST);
        fb.push_back(HDR_SECOND);
        fb.push_back(pkt);
        fb.push_back(8'($urandom));
        fb.push_back(len);
        if (len >= MIN_LEN)
        begin
            sum = {8'h00, pkt} + {8'h00, len};
            for (int i = 0; i < int'(len) - 2; i++)
            begin
                pb  = all_ones ? 8'hFF : 8'($urandom);
                sum = sum + {8'h00, pb};
                fb.push_back(pb);
            end
            if (!sum_good)
                sum = sum ^ 16'($urandom_range(1, 65535));
            fb.push_back(sum[15:8]);
            fb.push_back(sum[7:0]);
        end
        n = chop ? $urandom_range(1, fb.size() - 1) : fb.size();
        for (int i = 0; i < n; i++)
            send_byte(fb[i], i == 0, 1'b1);
    endtask

    function automatic logic [7:0] pick_length();
        int roll;
        roll = $urandom_range(0, 149);
        if (roll == 0)
            return 8'hFF;
        if (roll < 4)
            return 8'($urandom_range(13, 255));
        return 8'($urandom_range(2, 12));
    endfunction

    // Result side: mostly ready, short random stalls, and one long hold-off
    // so the held verdict backs up and in_ready drops.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!squeeze_done && bytes_sent >= SQUEEZE_AT)
            begin
                out_ready <= 1'b0;
                repeat (SQUEEZE_LEN) @(negedge clk);
                squeeze_done = 1;
            end
            else if (gaps_allowed() && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    // Verdict transfers are taken at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_verdict(frame_ok, status, packet_type);
    end

    // Watchdog: far beyond the slowest legal run (every byte gapped, every
    // verdict stalled, long frames included).
    initial
    begin
        #5_000_000;
        $display("frame_sum_checker verification failed");
        $finish;
    end

    initial
    begin
        int roll;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        first     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: stray byte after reset, both header faults, both short
        // lengths, empty payload with extreme type, checksum mismatch
        send_byte(8'h5A, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(HDR_FIRST, 1'b1, 1'b1);
        send_byte(8'hFE, 1'b0, 1'b1);
        send_frame(8'h00, 8'd0, 1'b0, 1'b1, 1'b0);
        send_frame(8'hFF, 8'd1, 1'b0, 1'b1, 1'b0);
        send_frame(8'hFF, 8'd2, 1'b0, 1'b1, 1'b0);
        send_frame(8'h3C, 8'd3, 1'b1, 1'b0, 1'b0);

        // random: mostly well-formed frames, the rest faults and noise
        while (bytes_sent < BYTE_TARGET)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                send_frame(8'($urandom), pick_length(), $urandom_range(0, 3) == 0,
                           1'b1, 1'b0);
            else if (roll < 70)
                send_frame(8'($urandom), pick_length(), 1'b0, 1'b0, 1'b0);
            else if (roll < 76)
                send_byte(8'($urandom), 1'b1, 1'b1);
            else if (roll < 82)
            begin
                send_byte(HDR_FIRST, 1'b1, 1'b1);
                send_byte(8'($urandom), 1'b0, 1'b1);
            end
            else if (roll < 88)
                send_frame(8'($urandom), 8'($urandom_range(0, 1)), 1'b0, 1'b1, 1'b0);
            else if (roll < 94)
                send_frame(8'($urandom), pick_length(), 1'b0, 1'b1, 1'b1);
            else
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, 1'b0);
        end
        in_valid <= 1'b0;

        while (board.verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("frame_sum_checker verification clean");
        else
            $display("frame_sum_checker verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/fsc_pkg.sv
sv/fsc_in_reg.sv
sv/fsc_parse.sv
sv/fsc_out_reg.sv
sv/frame_sum_checker.sv
sv/fsc_checker.sv
bench/frame_sum_checker_tb.sv
